// ----- rtl/core/sprite_blit_clip_color_key_unit_assert.svh -----
// Assertion macros for the sprite blitter, compiled out when SYNTH is defined.
`ifndef SPRITE_BLIT_CLIP_COLOR_KEY_UNIT_ASSERT_SVH
`define SPRITE_BLIT_CLIP_COLOR_KEY_UNIT_ASSERT_SVH
`ifndef SYNTH
`define SBCCK_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("sprite blitter check failed");
`define SBCCK_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sprite blitter check failed");
`else
`define SBCCK_ASSERT(lbl, prop)
`define SBCCK_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// ----- rtl/core/sbcck_pkg.sv -----
// Package with register map, field widths and defaults of the sprite blitter.
package sbcck_pkg;

    localparam int SCREEN_W_DEF       = 320;
    localparam int SCREEN_H_DEF       = 240;
    localparam int MAX_SPRITE_DIM_DEF = 256;

    localparam int APB_DW   = 32;
    localparam int APB_AW   = 5;
    localparam int COLOR_W  = 16;
    localparam int ADDR_W   = 17;
    localparam int POS_CFG_W = 12;
    localparam int DIM_CFG_W = 9;
    localparam int FSEL_W   = 8;
    localparam int FCNT_W   = 9;

    localparam logic [COLOR_W-1:0] COLOR_KEY = 16'd1;

    typedef enum logic [2:0] {
        REG_DEST_X,
        REG_DEST_Y,
        REG_SPRITE_WIDTH,
        REG_SPRITE_HEIGHT,
        REG_CENTER_MODE,
        REG_FRAME_SELECT,
        REG_FRAME_COUNT
    } t_reg_idx;

endpackage

// ----- rtl/core/sprite_blit_clip_color_key_unit.sv -----
// Top level of the sprite blitter with screen clipping and color key.
//
// Channel   Direction  Handshake                        Payload
// texel     in         i_texel_valid / o_texel_ready    i_texel_color
// pixel     out        o_pixel_valid / i_pixel_ready    write enable, address, color, done
// config    in         APB psel/penable/pwrite, pready  paddr, pwdata, prdata
//
// Each beat passes an input register and a result register; one texel is accepted every
// cycle while the output is not stalled.
// The column and row counters advance when a texel moves into the result register.
// A stall on the output side holds both stages; the input register refills as soon as
// the result register is taken.
// Synchronous active-low reset clears counters and valid flags and sets config defaults.

`include "sprite_blit_clip_color_key_unit_assert.svh"

module sprite_blit_clip_color_key_unit
    import sbcck_pkg::*;
#(
    parameter int SCREEN_W       = SCREEN_W_DEF,
    parameter int SCREEN_H       = SCREEN_H_DEF,
    parameter int MAX_SPRITE_DIM = MAX_SPRITE_DIM_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_texel_valid,
    output logic                 o_texel_ready,
    input  logic [COLOR_W-1:0]   i_texel_color,
    output logic                 o_pixel_valid,
    input  logic                 i_pixel_ready,
    output logic                 o_write_enable,
    output logic [ADDR_W-1:0]    o_pixel_address,
    output logic [COLOR_W-1:0]   o_pixel_color,
    output logic                 o_sprite_done,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    localparam int CNT_W = (MAX_SPRITE_DIM > 1) ? $clog2(MAX_SPRITE_DIM) : 1;
    localparam int DIM_W = $clog2(MAX_SPRITE_DIM + 1);
    localparam int EW    = (DIM_W > DIM_CFG_W) ? DIM_W : DIM_CFG_W;
    localparam int PW    = ((EW > POS_CFG_W) ? EW : POS_CFG_W) + 2;
    localparam int MW    = PW + 11;

    logic signed [POS_CFG_W-1:0] r_dest_x;
    logic signed [POS_CFG_W-1:0] r_dest_y;
    logic [DIM_CFG_W-1:0]        r_sprite_width;
    logic [DIM_CFG_W-1:0]        r_sprite_height;
    logic                        r_center_mode;
    logic [FSEL_W-1:0]           r_frame_select;
    logic [FCNT_W-1:0]           r_frame_count;

    logic                        r_s1_valid;
    logic [COLOR_W-1:0]          r_s1_color;
    logic [CNT_W-1:0]            r_col;
    logic [CNT_W-1:0]            r_row;
    logic [CNT_W-1:0]            n_col;
    logic [CNT_W-1:0]            n_row;

    logic                        r_out_valid;
    logic                        r_we;
    logic [ADDR_W-1:0]           r_addr;
    logic [COLOR_W-1:0]          r_color;
    logic                        r_done;

    logic                        cfg_wr;
    t_reg_idx                    cfg_idx;
    logic                        out_free;
    logic                        s1_free;
    logic                        s1_move;
    logic [EW-1:0]               wide_w;
    logic [EW-1:0]               wide_h;
    logic [EW-1:0]               eff_w;
    logic [EW-1:0]               eff_h;
    logic                        row_end;
    logic                        last;
    logic signed [PW-1:0]        pos_x;
    logic signed [PW-1:0]        pos_y;
    logic                        in_screen;
    logic                        we;
    logic [MW-1:0]               addr_full;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_x        <= '0;
            r_dest_y        <= '0;
            r_sprite_width  <= DIM_CFG_W'(1);
            r_sprite_height <= DIM_CFG_W'(1);
            r_center_mode   <= 1'b0;
            r_frame_select  <= '0;
            r_frame_count   <= FCNT_W'(1);
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_DEST_X:        r_dest_x        <= pwdata[POS_CFG_W-1:0];
                REG_DEST_Y:        r_dest_y        <= pwdata[POS_CFG_W-1:0];
                REG_SPRITE_WIDTH:  r_sprite_width  <= pwdata[DIM_CFG_W-1:0];
                REG_SPRITE_HEIGHT: r_sprite_height <= pwdata[DIM_CFG_W-1:0];
                REG_CENTER_MODE:   r_center_mode   <= pwdata[0];
                REG_FRAME_SELECT:  r_frame_select  <= pwdata[FSEL_W-1:0];
                REG_FRAME_COUNT:   r_frame_count   <= pwdata[FCNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_DEST_X:        prdata = APB_DW'(unsigned'(r_dest_x));
            REG_DEST_Y:        prdata = APB_DW'(unsigned'(r_dest_y));
            REG_SPRITE_WIDTH:  prdata = APB_DW'(r_sprite_width);
            REG_SPRITE_HEIGHT: prdata = APB_DW'(r_sprite_height);
            REG_CENTER_MODE:   prdata = APB_DW'(r_center_mode);
            REG_FRAME_SELECT:  prdata = APB_DW'(r_frame_select);
            REG_FRAME_COUNT:   prdata = APB_DW'(r_frame_count);
            default:           prdata = '0;
        endcase
    end

    assign out_free      = !r_out_valid || i_pixel_ready;
    assign s1_move       = r_s1_valid && out_free;
    assign s1_free       = !r_s1_valid || out_free;
    assign o_texel_ready = s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= i_texel_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free && i_texel_valid) begin
            r_s1_color <= i_texel_color;
        end
    end

    always_comb begin
        wide_w = EW'(r_sprite_width);
        wide_h = EW'(r_sprite_height);
        if (wide_w == '0) begin
            eff_w = EW'(1);
        end else if (wide_w > EW'(MAX_SPRITE_DIM)) begin
            eff_w = EW'(MAX_SPRITE_DIM);
        end else begin
            eff_w = wide_w;
        end
        if (wide_h == '0) begin
            eff_h = EW'(1);
        end else if (wide_h > EW'(MAX_SPRITE_DIM)) begin
            eff_h = EW'(MAX_SPRITE_DIM);
        end else begin
            eff_h = wide_h;
        end

        row_end = (EW'(r_col) + EW'(1)) >= eff_w;
        last    = row_end && ((EW'(r_row) + EW'(1)) >= eff_h);

        pos_x = {{(PW-POS_CFG_W){r_dest_x[POS_CFG_W-1]}}, r_dest_x} + PW'(r_col)
              - (r_center_mode ? PW'(eff_w >> 1) : PW'(0));
        pos_y = {{(PW-POS_CFG_W){r_dest_y[POS_CFG_W-1]}}, r_dest_y} + PW'(r_row)
              - (r_center_mode ? PW'(eff_h >> 1) : PW'(0));

        in_screen = !pos_x[PW-1] && !pos_y[PW-1]
                 && (pos_x[PW-2:0] < (PW-1)'(SCREEN_W))
                 && (pos_y[PW-2:0] < (PW-1)'(SCREEN_H));
        we = (r_s1_color != COLOR_KEY) && ({1'b0, r_frame_select} < r_frame_count)
          && in_screen;

        addr_full = MW'(pos_y[PW-2:0]) * MW'(SCREEN_W) + MW'(pos_x[PW-2:0]);

        if (row_end) begin
            n_col = '0;
            n_row = last ? '0 : r_row + CNT_W'(1);
        end else begin
            n_col = r_col + CNT_W'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_move) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_we    <= we;
            r_addr  <= we ? addr_full[ADDR_W-1:0] : '0;
            r_color <= we ? r_s1_color : '0;
            r_done  <= last;
        end
    end

    assign o_pixel_valid   = r_out_valid;
    assign o_write_enable  = r_we;
    assign o_pixel_address = r_addr;
    assign o_pixel_color   = r_color;
    assign o_sprite_done   = r_done;

    `SBCCK_ASSERT_IMP(a_idle_write_zero, o_pixel_valid && !o_write_enable, o_pixel_address == '0 && o_pixel_color == '0)
    `SBCCK_ASSERT_IMP(a_key_never_written, o_pixel_valid && o_write_enable, o_pixel_color != COLOR_KEY)
    `SBCCK_ASSERT_IMP(a_counters_wrap_on_done, s1_move && last, n_col == '0 && n_row == '0)

endmodule
